/* rtl/isqrt_pkg.sv */
// Package for the integer square root block.
// Holds the fixed port widths and the default build constants.
// Has no dependencies.
`timescale 1ns / 1ps

package isqrt_pkg;

    localparam int RADICAND_W       = 64;
    localparam int ROOT_BITS        = 32;
    localparam int WIDTH_DEFAULT    = 64;
    localparam int ROUNDS_PER_STAGE = 2;

endpackage

/* rtl/isqrt_stage.sv */
// One pipeline stage of the digit-by-digit square root.
// Runs a fixed group of restoring rounds on the remainder and partial root.
// Depends on isqrt_pkg.
`timescale 1ns / 1ps

module isqrt_stage
    import isqrt_pkg::*;
#(
    parameter int WIDTH       = WIDTH_DEFAULT,
    parameter int FIRST_ROUND = 0,
    parameter int NUM_ROUNDS  = ROUNDS_PER_STAGE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_rem,
    input  logic [WIDTH-1:0] in_acc,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_rem,
    output logic [WIDTH-1:0] out_acc
);

    localparam int TOP_POS = ((WIDTH - 1) / 2) * 2;

    logic             valid_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] acc_next;
    logic             load;

    always_comb begin
        logic [WIDTH:0]   rem_v;
        logic [WIDTH:0]   acc_v;
        logic [WIDTH:0]   cand_v;
        logic [WIDTH:0]   trial_v;
        rem_v = {1'b0, in_rem};
        acc_v = {1'b0, in_acc};
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            trial_v = (WIDTH + 1)'(1) << (TOP_POS - 2 * (FIRST_ROUND + i));
            cand_v  = acc_v + trial_v;
            if (rem_v >= cand_v) begin
                rem_v = rem_v - cand_v;
                acc_v = cand_v + trial_v;
            end
            acc_v = acc_v >> 1;
        end
        rem_next = rem_v[WIDTH-1:0];
        acc_next = acc_v[WIDTH-1:0];
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;

endmodule

/* rtl/integer_square_root_top.sv */
// Top level of the pipelined integer square root.
// Chains isqrt_stage instances; uses isqrt_pkg.
//
// Usage: the input channel (s_valid, s_ready, s_radicand) takes one unsigned
// radicand per transfer, and the result channel (m_valid, m_ready, m_root)
// returns the floor of its square root, in the same order. Only the low WIDTH
// bits of the radicand are used.
// Pipeline: each transfer passes through NUM_STAGES registered stages, where
// NUM_STAGES is the number of restoring rounds, (WIDTH + 1) / 2, divided by
// RPS (ROUNDS_PER_STAGE by default) and rounded up.
// Throughput: one transfer per cycle on each side while m_ready is high; each
// stage register holds one item, so items follow each other with no gaps.
// Reset: all stage valid bits clear, so the pipeline is empty and s_ready is
// high in the first cycle after reset.
// Stall: while m_ready is low the stages still fill from the front until every
// stage holds an item; only then does s_ready fall. No item is lost or repeated.
`timescale 1ns / 1ps

module integer_square_root_top
    import isqrt_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT,
    parameter int RPS   = ROUNDS_PER_STAGE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RADICAND_W-1:0] s_radicand,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROOT_BITS-1:0]  m_root
);

    localparam int ROUNDS     = (WIDTH + 1) / 2;
    localparam int ROOT_W     = ROUNDS;
    localparam int NUM_STAGES = (ROUNDS + RPS - 1) / RPS;

    logic             valid_w [NUM_STAGES+1];
    logic             ready_w [NUM_STAGES+1];
    logic [WIDTH-1:0] rem_w   [NUM_STAGES+1];
    logic [WIDTH-1:0] acc_w   [NUM_STAGES+1];

    assign valid_w[0] = s_valid;
    assign s_ready    = ready_w[0];
    assign rem_w[0]   = s_radicand[WIDTH-1:0];
    assign acc_w[0]   = '0;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int FIRST = s * RPS;
        localparam int LEFT  = ROUNDS - FIRST;
        localparam int COUNT = (LEFT < RPS) ? LEFT : RPS;

        isqrt_stage #(
            .WIDTH       (WIDTH),
            .FIRST_ROUND (FIRST),
            .NUM_ROUNDS  (COUNT)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[s]),
            .in_ready  (ready_w[s]),
            .in_rem    (rem_w[s]),
            .in_acc    (acc_w[s]),
            .out_valid (valid_w[s+1]),
            .out_ready (ready_w[s+1]),
            .out_rem   (rem_w[s+1]),
            .out_acc   (acc_w[s+1])
        );
    end

    assign ready_w[NUM_STAGES] = m_ready;
    assign m_valid             = valid_w[NUM_STAGES];
    assign m_root              = ROOT_BITS'(acc_w[NUM_STAGES][ROOT_W-1:0]);

    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready fell while the output was draining or empty");

    a_drain_open : assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while the output was being taken");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
